### src/sdw_pkg.sv
// Shared types for the spectral divergence/vorticity to wind block.
// Holds the coefficient width and the per-result operand bundle.
// No dependencies.
package sdw_pkg;

  localparam int CoefW = 32;
  localparam int CfgW  = 10;

  typedef logic signed [CoefW-1:0] coef_t;

  // Operands of one wind result: neighbor below (prev), own coefficient,
  // neighbor above (next), own f and g, g of the neighbor above.
  typedef struct packed {
    coef_t op_re;
    coef_t op_im;
    coef_t dp_re;
    coef_t dp_im;
    coef_t dc_re;
    coef_t dc_im;
    coef_t oc_re;
    coef_t oc_im;
    coef_t dn_re;
    coef_t dn_im;
    coef_t on_re;
    coef_t on_im;
    coef_t f;
    coef_t g;
    coef_t gn;
    logic  lend;
  } sdw_job_t;

endpackage

### src/spectral_div_vort_to_wind_core.sv
// Top level of the spectral divergence/vorticity to wind block.
// Tracks the (m,n) position, holds neighbor coefficients, issues result operands.
// Depends on sdw_pkg and sdw_wind_calc.
//
// Coefficients arrive in m-major order with their f and g factors, one request
// per cycle while in_ready is high. The wind result of coefficient n leaves once
// coefficient n+1 of the same column has been accepted; the request at
// n = truncation releases both the pending result and its own, so when its
// column has more than one coefficient its own result is queued and in_ready
// stays low until that result is taken (the single product datapath takes one
// result per cycle while its output is not stalled). A result passes through
// the operand register, product register and result register. The own result
// of a column end that also releases a pending one follows that one. Writing
// truncation restarts the stream at (0,0); values above TRUNC_MAX act as TRUNC_MAX.
module spectral_div_vort_to_wind_core #(
  parameter int TRUNC_MAX        = 1023,
  parameter int FACTOR_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sdw_pkg::CfgW-1:0]      truncation,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sdw_pkg::coef_t                div_re,
  input  sdw_pkg::coef_t                div_im,
  input  sdw_pkg::coef_t                vort_re,
  input  sdw_pkg::coef_t                vort_im,
  input  sdw_pkg::coef_t                f_factor,
  input  sdw_pkg::coef_t                g_factor,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sdw_pkg::coef_t                u_re,
  output sdw_pkg::coef_t                u_im,
  output sdw_pkg::coef_t                v_re,
  output sdw_pkg::coef_t                v_im,
  output logic                          level_end
);
  import sdw_pkg::*;

  localparam int PosW = $clog2(TRUNC_MAX + 1);
  localparam int CmpW = (PosW > CfgW) ? PosW : CfgW;

  logic [CfgW-1:0] trunc;
  logic [PosW-1:0] order_m;
  logic [PosW-1:0] degree_n;
  logic            held_valid;
  coef_t           prev_d_re, prev_d_im, prev_o_re, prev_o_im;
  coef_t           held_d_re, held_d_im, held_o_re, held_o_im;
  coef_t           held_f, held_g;
  logic            pend_valid;
  sdw_job_t        pend_job;

  logic [CmpW-1:0] trunc_ext;
  logic [PosW-1:0] t_eff;
  logic            restart;
  logic [PosW-1:0] m_eff;
  logic [PosW-1:0] n_eff;
  logic            hv_eff;
  logic            last;
  logic [PosW-1:0] m_wrap;
  coef_t           dcur_re, dcur_im, ocur_re, ocur_im;
  sdw_job_t        job_a;
  sdw_job_t        job_b;
  sdw_job_t        job;
  logic            job_valid;
  logic            job_ready;
  logic            in_acc;
  logic            cfg_acc;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_comb begin
    trunc_ext = CmpW'(trunc);
    t_eff     = (trunc_ext > CmpW'(TRUNC_MAX)) ? PosW'(TRUNC_MAX) : PosW'(trunc_ext);
    restart   = (order_m > t_eff) || (degree_n > t_eff) || (degree_n < order_m);
    m_eff     = restart ? '0 : order_m;
    n_eff     = restart ? '0 : degree_n;
    hv_eff    = restart ? 1'b0 : held_valid;
    last      = (n_eff == t_eff);
    m_wrap    = (m_eff == t_eff) ? '0 : m_eff + 1'b1;
    dcur_re   = last ? '0 : div_re;
    dcur_im   = last ? '0 : div_im;
    ocur_re   = last ? '0 : vort_re;
    ocur_im   = last ? '0 : vort_im;
  end

  always_comb begin
    job_a.op_re = prev_o_re;
    job_a.op_im = prev_o_im;
    job_a.dp_re = prev_d_re;
    job_a.dp_im = prev_d_im;
    job_a.dc_re = held_d_re;
    job_a.dc_im = held_d_im;
    job_a.oc_re = held_o_re;
    job_a.oc_im = held_o_im;
    job_a.dn_re = dcur_re;
    job_a.dn_im = dcur_im;
    job_a.on_re = ocur_re;
    job_a.on_im = ocur_im;
    job_a.f     = held_f;
    job_a.g     = held_g;
    job_a.gn    = g_factor;
    job_a.lend  = 1'b0;

    job_b.op_re = hv_eff ? held_o_re : '0;
    job_b.op_im = hv_eff ? held_o_im : '0;
    job_b.dp_re = hv_eff ? held_d_re : '0;
    job_b.dp_im = hv_eff ? held_d_im : '0;
    job_b.dc_re = '0;
    job_b.dc_im = '0;
    job_b.oc_re = '0;
    job_b.oc_im = '0;
    job_b.dn_re = '0;
    job_b.dn_im = '0;
    job_b.on_re = '0;
    job_b.on_im = '0;
    job_b.f     = f_factor;
    job_b.g     = g_factor;
    job_b.gn    = '0;
    job_b.lend  = (m_eff == t_eff);
  end

  assign in_ready  = !pend_valid && job_ready;
  assign in_acc    = in_valid && in_ready;
  assign job_valid = pend_valid || (in_valid && (hv_eff || last));
  assign job       = pend_valid ? pend_job : (hv_eff ? job_a : job_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      trunc      <= CfgW'(63);
      order_m    <= '0;
      degree_n   <= '0;
      held_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (in_acc && hv_eff && last) begin
        pend_valid <= 1'b1;
      end else if (pend_valid && job_ready) begin
        pend_valid <= 1'b0;
      end
      if (cfg_acc) begin
        trunc      <= truncation;
        order_m    <= '0;
        degree_n   <= '0;
        held_valid <= 1'b0;
      end else if (in_acc) begin
        if (last) begin
          order_m    <= m_wrap;
          degree_n   <= m_wrap;
          held_valid <= 1'b0;
        end else begin
          order_m    <= m_eff;
          degree_n   <= n_eff + 1'b1;
          held_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && hv_eff && last) begin
      pend_job <= job_b;
    end
    if (in_acc) begin
      prev_d_re <= hv_eff ? held_d_re : '0;
      prev_d_im <= hv_eff ? held_d_im : '0;
      prev_o_re <= hv_eff ? held_o_re : '0;
      prev_o_im <= hv_eff ? held_o_im : '0;
      held_d_re <= dcur_re;
      held_d_im <= dcur_im;
      held_o_re <= ocur_re;
      held_o_im <= ocur_im;
      held_f    <= f_factor;
      held_g    <= g_factor;
    end
  end

  sdw_wind_calc #(
    .FACTOR_FRAC_BITS(FACTOR_FRAC_BITS)
  ) u_calc (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .u_re      (u_re),
    .u_im      (u_im),
    .v_re      (v_re),
    .v_im      (v_im),
    .level_end (level_end)
  );

  a_pend_blocks_input: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !in_ready)
    else $error("input taken while a second result is pending");

  a_column_end_pends: assert property (@(posedge clk) disable iff (rst)
    (in_acc && hv_eff && last) |=> pend_valid)
    else $error("column end did not queue its own result");

  a_column_end_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && last) |=> !held_valid)
    else $error("held coefficient survives the column end");

  a_held_position: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (degree_n > order_m))
    else $error("held coefficient at the column start");

endmodule

### src/sdw_wind_calc.sv
// Wind coefficient datapath: operand register, product register, result register.
// Forms twelve scaled products per result and sums them with saturation.
// Depends on sdw_pkg.
module sdw_wind_calc #(
  parameter int FACTOR_FRAC_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   job_valid,
  output logic                   job_ready,
  input  sdw_pkg::sdw_job_t      job,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sdw_pkg::coef_t         u_re,
  output sdw_pkg::coef_t         u_im,
  output sdw_pkg::coef_t         v_re,
  output sdw_pkg::coef_t         v_im,
  output logic                   level_end
);
  import sdw_pkg::*;

  localparam int ProdW = 2 * CoefW;
  localparam int SumW  = ProdW + 2;
  localparam logic signed [SumW-1:0] SatMax = SumW'((64'sd1 <<< (CoefW - 1)) - 64'sd1);
  localparam logic signed [SumW-1:0] SatMin = -SumW'(64'sd1 <<< (CoefW - 1));

  logic                     s1_valid;
  sdw_job_t                 s1_job;
  logic                     s2_valid;
  logic                     s2_lend;
  logic signed [ProdW-1:0]  s2_term [12];
  logic signed [ProdW-1:0]  term_next [12];
  logic                     s2_adv;
  logic                     s3_adv;
  logic signed [SumW-1:0]   sum_u_re;
  logic signed [SumW-1:0]   sum_u_im;
  logic signed [SumW-1:0]   sum_v_re;
  logic signed [SumW-1:0]   sum_v_im;

  function automatic logic signed [ProdW-1:0] term(input coef_t c, input coef_t x);
    logic signed [ProdW-1:0] p;
    p = ProdW'(c) * ProdW'(x);
    return p >>> FACTOR_FRAC_BITS;
  endfunction

  function automatic coef_t sat(input logic signed [SumW-1:0] s);
    coef_t r;
    if (s > SatMax) begin
      r = SatMax[CoefW-1:0];
    end else if (s < SatMin) begin
      r = SatMin[CoefW-1:0];
    end else begin
      r = s[CoefW-1:0];
    end
    return r;
  endfunction

  assign s3_adv    = !out_valid || out_ready;
  assign s2_adv    = !s2_valid || s3_adv;
  assign job_ready = !s1_valid || s2_adv;

  always_comb begin
    term_next[0]  = term(s1_job.op_re, s1_job.g);
    term_next[1]  = term(s1_job.dc_im, s1_job.f);
    term_next[2]  = term(s1_job.on_re, s1_job.gn);
    term_next[3]  = term(s1_job.op_im, s1_job.g);
    term_next[4]  = term(s1_job.dc_re, s1_job.f);
    term_next[5]  = term(s1_job.on_im, s1_job.gn);
    term_next[6]  = term(s1_job.dp_re, s1_job.g);
    term_next[7]  = term(s1_job.oc_im, s1_job.f);
    term_next[8]  = term(s1_job.dn_re, s1_job.gn);
    term_next[9]  = term(s1_job.dp_im, s1_job.g);
    term_next[10] = term(s1_job.oc_re, s1_job.f);
    term_next[11] = term(s1_job.dn_im, s1_job.gn);
  end

  always_comb begin
    sum_u_re = SumW'(s2_term[0]) - SumW'(s2_term[1]) - SumW'(s2_term[2]);
    sum_u_im = SumW'(s2_term[3]) + SumW'(s2_term[4]) - SumW'(s2_term[5]);
    sum_v_re = SumW'(s2_term[8]) - SumW'(s2_term[6]) - SumW'(s2_term[7]);
    sum_v_im = SumW'(s2_term[10]) + SumW'(s2_term[11]) - SumW'(s2_term[9]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job_ready) begin
        s1_valid <= job_valid;
      end
      if (s2_adv) begin
        s2_valid <= s1_valid;
      end
      if (s3_adv) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      s1_job <= job;
    end
    if (s2_adv && s1_valid) begin
      s2_term <= term_next;
      s2_lend <= s1_job.lend;
    end
    if (s3_adv && s2_valid) begin
      u_re      <= sat(sum_u_re);
      u_im      <= sat(sum_u_im);
      v_re      <= sat(sum_v_re);
      v_im      <= sat(sum_v_im);
      level_end <= s2_lend;
    end
  end

endmodule
